[src/kwc_pkg.sv]
// Shared types and constants of the keyword substitution cipher.
package kwc_pkg;

    localparam int unsigned ALPHA_SIZE = 26;
    localparam int unsigned LETTER_W   = 5;

    // Input command codes
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_KEY   = 2'd1;
    localparam logic [1:0] CMD_MSG   = 2'd2;

    // Operation codes carried through the queue
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_KEY   = 2'd1;
    localparam logic [1:0] OP_MSG   = 2'd2;

    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_Z     = 8'h7a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UNDER = 8'h5f;

    localparam logic [LETTER_W-1:0] LAST_LETTER = LETTER_W'(ALPHA_SIZE - 1);
    localparam logic [LETTER_W-1:0] TABLE_FULL  = LETTER_W'(ALPHA_SIZE);

    typedef struct packed {
        logic [1:0]          op;
        logic                space;   // message byte is a space or underscore
        logic [LETTER_W-1:0] idx;     // letter index, zero for other bytes
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_head;

endpackage

[src/kwc_front.sv]
// Front end: accepts input transactions, classifies them and queues the operations.
module kwc_front
    import kwc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_char_in,
    output t_head      o_head,
    input  logic       i_pop
);

    logic       w_lower;
    logic       w_keep;
    t_op        w_op;
    logic       w_push;

    t_op        r_q [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;

    assign w_lower = (i_char_in >= CH_A) && (i_char_in <= CH_Z);

    always_comb begin
        w_op.op    = OP_CLEAR;
        w_op.space = 1'b0;
        w_op.idx   = '0;
        w_keep     = 1'b0;
        unique case (i_cmd)
            CMD_CLEAR: begin
                w_keep = 1'b1;
            end
            CMD_KEY: begin
                // drop keyword bytes that are not lowercase letters
                w_op.op  = OP_KEY;
                w_op.idx = LETTER_W'(i_char_in - CH_A);
                w_keep   = w_lower;
            end
            CMD_MSG: begin
                w_op.op    = OP_MSG;
                w_op.space = (i_char_in == CH_SPACE) || (i_char_in == CH_UNDER);
                w_op.idx   = w_lower ? LETTER_W'(i_char_in - CH_A) : '0;
                w_keep     = 1'b1;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign o_stall = (r_count == 2'd2);
    assign w_push  = i_valid && !o_stall && w_keep;

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ w_push;
        n_rd_ptr = r_rd_ptr ^ i_pop;
        n_count  = r_count + {1'b0, w_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_op;
        end
    end

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.op    = r_q[r_rd_ptr];

endmodule

[src/kwc_back.sv]
// Back end: key table state, completion walk and encryption output register.
module kwc_back
    import kwc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_head      i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_char_out
);

    localparam logic ST_RUN  = 1'b0;
    localparam logic ST_FILL = 1'b1;

    logic                r_state, n_state;
    logic [LETTER_W-1:0] r_fill_k, n_fill_k;
    logic [ALPHA_SIZE-1:0] r_used, n_used;
    logic [LETTER_W-1:0] r_count, n_count;
    logic                r_complete, n_complete;
    logic [LETTER_W-1:0] r_table [ALPHA_SIZE];
    logic                r_out_valid, n_out_valid;
    logic [7:0]          r_out_char;

    logic                w_out_free;
    logic                w_add;
    logic [LETTER_W-1:0] w_letter;
    logic                w_write;
    logic                w_load;
    logic [7:0]          w_char;

    assign w_out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state    = r_state;
        n_fill_k   = r_fill_k;
        n_complete = r_complete;
        o_pop      = 1'b0;
        w_add      = 1'b0;
        w_letter   = i_head.op.idx;
        w_load     = 1'b0;
        unique case (r_state)
            ST_RUN: begin
                if (i_head.valid) begin
                    case (i_head.op.op)
                        OP_CLEAR: begin
                            o_pop      = 1'b1;
                            n_complete = 1'b0;
                        end
                        OP_KEY: begin
                            o_pop = 1'b1;
                            w_add = 1'b1;
                        end
                        default: begin
                            if (!r_complete) begin
                                // hold the message, append unused letters first
                                n_state  = ST_FILL;
                                n_fill_k = '0;
                            end else if (w_out_free) begin
                                o_pop  = 1'b1;
                                w_load = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_FILL: begin
                w_add    = 1'b1;
                w_letter = r_fill_k;
                n_fill_k = r_fill_k + 1'b1;
                if (r_fill_k == LAST_LETTER) begin
                    n_state    = ST_RUN;
                    n_complete = 1'b1;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    assign w_write = w_add && !r_used[w_letter] && (r_count < TABLE_FULL);

    always_comb begin
        n_used  = r_used;
        n_count = r_count;
        if (o_pop && i_head.op.op == OP_CLEAR) begin
            n_used  = '0;
            n_count = '0;
        end else if (w_add) begin
            n_used[w_letter] = 1'b1;
            if (w_write) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    assign w_char = i_head.op.space ? CH_SPACE
                                    : CH_A + {3'b000, r_table[i_head.op.idx]};

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_fill_k    <= '0;
            r_used      <= '0;
            r_count     <= '0;
            r_complete  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill_k    <= n_fill_k;
            r_used      <= n_used;
            r_count     <= n_count;
            r_complete  <= n_complete;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_table[r_count] <= w_letter;
        end
        if (w_load) begin
            r_out_char <= w_char;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_char_out = r_out_char;

endmodule

[src/keyword_substitution_cipher_top.sv]
// Top level of the keyword substitution cipher: front end, queue and back end.
//
//  Channel   Handshake            Payload
//  input     i_valid / o_stall    i_cmd[1:0], i_char_in[7:0]
//  output    o_valid / i_stall    o_char_out[7:0]
//
// The back end pops clear and keyword transactions once they head the queue.
// A message waits for a free output register; the first one after reset or a
// clear waits in ST_FILL first, which walks the alphabet to complete the table.
// Reset clears the key; the table contents are written before they are read.
// A two-entry queue lets the front keep accepting while the output is stalled.
module keyword_substitution_cipher_top
    import kwc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_char_in,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_char_out
);

    t_head w_head;
    logic  w_pop;

    kwc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_cmd     (i_cmd),
        .i_char_in (i_char_in),
        .o_head    (w_head),
        .i_pop     (w_pop)
    );

    kwc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_char_out (o_char_out)
    );

    a_pop_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.valid)
        else $error("pop from empty queue");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_char_out == CH_SPACE) ||
                    ((o_char_out >= CH_A) && (o_char_out <= CH_Z)))
        else $error("output byte outside space and lowercase letters");

    a_out_from_msg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_pop && (w_head.op.op == OP_MSG)))
        else $error("result without a message transaction");

endmodule

[dv/keyword_substitution_cipher_checker.sv]
// Scoreboard for the keyword substitution cipher: tracks the keyword table and checks each output byte.
module keyword_substitution_cipher_checker
    import kwc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_char_in,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_char_out,
    output int         o_mismatches,
    output int         o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [LETTER_W-1:0]   alphabet_map [ALPHA_SIZE];
    logic [ALPHA_SIZE-1:0] letters_taken;
    logic [LETTER_W-1:0]   map_fill;
    logic                  map_done;
    logic [7:0]            cipher_q [$];
    logic [7:0]            want_char;
    int                    mismatch_count = 0;

    task automatic append_letter(input logic [LETTER_W-1:0] idx);
        if (!letters_taken[idx]) begin
            if (map_fill < TABLE_FULL) begin
                alphabet_map[map_fill] = idx;
                map_fill = map_fill + 1'b1;
            end
            letters_taken[idx] = 1'b1;
        end
    endtask

    task automatic absorb_transaction(input logic [1:0] cmd, input logic [7:0] ch);
        logic [7:0] cipher;
        case (cmd)
            CMD_CLEAR: begin
                // table entries survive a clear; only the bookkeeping drops
                letters_taken = '0;
                map_fill      = '0;
                map_done      = 1'b0;
            end
            CMD_KEY: begin
                if (ch >= CH_A && ch <= CH_Z) begin
                    append_letter(LETTER_W'(ch - CH_A));
                end
            end
            CMD_MSG: begin
                // first message byte after loading: fill in the unused letters in order
                if (!map_done) begin
                    for (int k = 0; k < ALPHA_SIZE; k++) begin
                        append_letter(LETTER_W'(k));
                    end
                    map_done = 1'b1;
                end
                if (ch == CH_SPACE || ch == CH_UNDER) begin
                    cipher = CH_SPACE;
                end else if (ch >= CH_A && ch <= CH_Z) begin
                    cipher = CH_A + 8'(alphabet_map[LETTER_W'(ch - CH_A)]);
                end else begin
                    cipher = CH_A + 8'(alphabet_map[0]);
                end
                cipher_q.push_back(cipher);
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (alphabet_map[k]) begin
                alphabet_map[k] = '0;
            end
            letters_taken = '0;
            map_fill      = '0;
            map_done      = 1'b0;
            cipher_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                absorb_transaction(i_cmd, i_char_in);
            end
            if (i_out_valid && !i_out_stall) begin
                if (cipher_q.size() == 0) begin
                    $display("%0t: unexpected char_out %h, expected none", $time, i_char_out);
                    mismatch_count++;
                end else begin
                    want_char = cipher_q.pop_front();
                    if (i_char_out !== want_char) begin
                        $display("%0t: char_out mismatch, expected %h, actual %h",
                                 $time, want_char, i_char_out);
                        mismatch_count++;
                    end
                end
            end
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= cipher_q.size();
    end

endmodule

[dv/keyword_substitution_cipher_top_tb.sv]
// Testbench top for the keyword substitution cipher: clock, reset, stimulus and verdict.
module keyword_substitution_cipher_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import kwc_pkg::*;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int ITEM_TARGET   = 900;
    localparam int CALM_AFTER    = 800;

    logic       i_clk;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic       o_stall;
    logic [1:0] i_cmd     = CMD_CLEAR;
    logic [7:0] i_char_in = 8'h00;
    logic       o_valid;
    logic       i_stall   = 1'b0;
    logic [7:0] o_char_out;

    int mismatches;
    int outstanding;
    int counted_items = 0;
    int cycle_count   = 0;
    int stall_left    = 0;
    bit idle_on       = 1'b1;

    keyword_substitution_cipher_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_cmd      (i_cmd),
        .i_char_in  (i_char_in),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_char_out (o_char_out)
    );

    keyword_substitution_cipher_checker cipher_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_cmd         (i_cmd),
        .i_char_in     (i_char_in),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_char_out    (o_char_out),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Output backpressure in random bursts while idle_on is set
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            i_stall <= 1'b1;
            stall_left = $urandom_range(0, 3);
        end else begin
            i_stall <= 1'b0;
        end
    end

    function automatic logic [7:0] random_char(input int letter_weight);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < letter_weight) begin
            return CH_A + 8'($urandom_range(0, ALPHA_SIZE - 1));
        end
        case ($urandom_range(0, 2))
            0:       return CH_SPACE;
            1:       return CH_UNDER;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_byte(input logic [1:0] cmd, input logic [7:0] ch);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_cmd     <= cmd;
        i_char_in <= ch;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        // ignored transactions do not count toward the target
        if (cmd != CMD_NONE && !(cmd == CMD_KEY && !(ch >= CH_A && ch <= CH_Z))) begin
            counted_items++;
        end
    endtask

    task automatic wait_for_drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    initial begin
        int key_len;
        int msg_len;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty keyword right after reset: plain alphabet
        send_byte(CMD_MSG, "a");
        send_byte(CMD_MSG, "z");
        send_byte(CMD_CLEAR, 8'hff);
        // Skip spaces, uppercase and other bytes; drop the repeated letter
        send_byte(CMD_KEY, " ");
        send_byte(CMD_KEY, "Z");
        send_byte(CMD_KEY, "z");
        send_byte(CMD_KEY, "e");
        send_byte(CMD_KEY, "b");
        send_byte(CMD_KEY, "r");
        send_byte(CMD_KEY, "a");
        send_byte(CMD_KEY, "z");
        send_byte(CMD_KEY, 8'hff);
        send_byte(CMD_KEY, 8'h00);
        send_byte(CMD_NONE, "x");
        send_byte(CMD_MSG, "a");
        send_byte(CMD_MSG, "z");
        send_byte(CMD_MSG, " ");
        send_byte(CMD_MSG, "_");
        send_byte(CMD_MSG, 8'h00);
        send_byte(CMD_MSG, 8'hff);
        send_byte(CMD_MSG, "A");
        send_byte(CMD_MSG, "m");
        // Keyword after the table is complete changes nothing
        send_byte(CMD_KEY, "q");
        send_byte(CMD_MSG, "q");
        send_byte(CMD_CLEAR, 8'h00);
        send_byte(CMD_MSG, "c");
        wait_for_drain();

        while (counted_items < ITEM_TARGET) begin
            if (counted_items >= CALM_AFTER) begin
                idle_on = 1'b0;
            end else begin
                idle_on = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 6)) begin
                    send_byte(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                end
            end else begin
                // Occasionally skip the clear so keyword bytes land on a complete table
                if ($urandom_range(0, 5) != 0) begin
                    send_byte(CMD_CLEAR, 8'($urandom_range(0, 255)));
                end
                key_len = $urandom_range(0, 10);
                repeat (key_len) send_byte(CMD_KEY, random_char(8));
                msg_len = $urandom_range(1, 20);
                repeat (msg_len) send_byte(CMD_MSG, random_char(7));
            end
            if ($urandom_range(0, 15) == 0) begin
                wait_for_drain();
            end
        end

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[files.f]
src/kwc_pkg.sv
src/kwc_front.sv
src/kwc_back.sv
src/keyword_substitution_cipher_top.sv
dv/keyword_substitution_cipher_checker.sv
dv/keyword_substitution_cipher_top_tb.sv
